// ===== rtl/chbd_pkg.sv =====
package chbd_pkg;

    localparam int ByteW  = 8;
    localparam int CountW = 32;
    localparam int PhaseW = 3;
    localparam int KindW  = 2;
    localparam int DigitW = 5;

    localparam logic [ByteW-1:0] CharCr = 8'h0D;
    localparam logic [ByteW-1:0] CharLf = 8'h0A;

    localparam logic [DigitW-1:0] HexNone = 5'd16;

    // phase codes
    localparam logic [PhaseW-1:0] PH_HEADER    = 3'd0;
    localparam logic [PhaseW-1:0] PH_SKIP_PRE  = 3'd1;
    localparam logic [PhaseW-1:0] PH_SIZE      = 3'd2;
    localparam logic [PhaseW-1:0] PH_SKIP_POST = 3'd3;
    localparam logic [PhaseW-1:0] PH_DATA      = 3'd4;
    localparam logic [PhaseW-1:0] PH_DONE      = 3'd5;

    // result kinds
    localparam logic [KindW-1:0] KIND_DROP   = 2'd0;
    localparam logic [KindW-1:0] KIND_HEADER = 2'd1;
    localparam logic [KindW-1:0] KIND_BODY   = 2'd2;

    typedef struct packed {
        logic [1:0]        header_match;
        logic [PhaseW-1:0] phase;
        logic [CountW-1:0] chunk_size;
        logic [CountW-1:0] bytes_left;
        logic [CountW-1:0] body_count;
    } dec_state_t;

    typedef struct packed {
        logic [ByteW-1:0]  out_byte;
        logic [KindW-1:0]  out_kind;
        logic              header_seen;
        logic [CountW-1:0] body_len;
    } dec_result_t;

    // 0..15 for a hex digit, HexNone otherwise
    function automatic logic [DigitW-1:0] hex_value(input logic [ByteW-1:0] b);
        logic [DigitW-1:0] v;
        v = HexNone;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        return v;
    endfunction

endpackage

// ===== rtl/chbd_step.sv =====
module chbd_step
    import chbd_pkg::*;
(
    input  dec_state_t       cur,
    input  logic [ByteW-1:0] data_byte,
    output dec_state_t       nxt,
    output dec_result_t      res
);

    logic              is_crlf;
    logic [DigitW-1:0] digit;
    logic [KindW-1:0]  kind;
    logic              want_lf;
    logic [ByteW-1:0]  want;

    assign is_crlf = (data_byte == CharCr) || (data_byte == CharLf);
    assign digit   = hex_value(data_byte);
    assign want_lf = cur.header_match[0];
    assign want    = want_lf ? CharLf : CharCr;

    always_comb begin
        nxt  = cur;
        kind = KIND_DROP;
        case (cur.phase)
            PH_HEADER: begin
                kind = KIND_HEADER;
                if (data_byte == want) begin
                    if (cur.header_match == 2'd3) begin
                        nxt.header_match = 2'd0;
                        nxt.phase        = PH_SKIP_PRE;
                    end else begin
                        nxt.header_match = cur.header_match + 2'd1;
                    end
                end else begin
                    nxt.header_match = (data_byte == CharCr) ? 2'd1 : 2'd0;
                end
            end
            PH_SKIP_PRE: begin
                if (!is_crlf) begin
                    if (digit != HexNone) begin
                        nxt.chunk_size = CountW'(digit[3:0]);
                        nxt.phase      = PH_SIZE;
                    end else begin
                        nxt.chunk_size = '0;
                        nxt.phase      = PH_DONE;
                    end
                end
            end
            PH_SIZE: begin
                if (!is_crlf && digit != HexNone) begin
                    // shift in one nibble, wraps mod 2^32
                    nxt.chunk_size = {cur.chunk_size[CountW-5:0], digit[3:0]};
                end else begin
                    nxt.phase = (cur.chunk_size == '0) ? PH_DONE : PH_SKIP_POST;
                end
            end
            PH_SKIP_POST: begin
                if (!is_crlf) begin
                    kind           = KIND_BODY;
                    nxt.bytes_left = cur.chunk_size - CountW'(1);
                    nxt.phase      = (cur.chunk_size == CountW'(1)) ? PH_SKIP_PRE : PH_DATA;
                end
            end
            PH_DATA: begin
                kind           = KIND_BODY;
                nxt.bytes_left = cur.bytes_left - CountW'(1);
                if (cur.bytes_left == CountW'(1)) begin
                    nxt.phase = PH_SKIP_PRE;
                end
            end
            default: begin
            end
        endcase

        if (kind == KIND_BODY && cur.body_count != '1) begin
            nxt.body_count = cur.body_count + CountW'(1);
        end

        res.out_byte    = (kind != KIND_DROP) ? data_byte : '0;
        res.out_kind    = kind;
        res.header_seen = (nxt.phase != PH_HEADER);
        res.body_len    = nxt.body_count;
    end

endmodule

// ===== rtl/http_chunked_body_decoder_unit.sv =====
// path: an accepted input word goes to the input register, its result word to the
// result register on m_axis; throughput: one word per cycle unless m_axis stalls;
// one input register, one result register, the combinational decode step between them
// reset: aresetn synchronous active low clears both stages and the decoder state;
// the decoder state also returns to reset after a word marked tlast is decoded
module http_chunked_body_decoder_unit
    import chbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [8] header_seen,
                                        // [40:9] body_len, [47:41] zero fill
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast    // end_of_message
);

    // input stage
    logic             in_valid_reg, in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;

    // result stage
    logic             out_valid_reg, out_valid_next;
    dec_result_t      out_res_reg;
    logic             out_last_reg;

    // decoder state
    dec_state_t       state_reg, state_next;
    dec_state_t       step_nxt;
    dec_result_t      step_res;

    logic out_free;
    logic step_fire;
    logic in_fire;

    // result slot frees up when empty or being drained this cycle
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign step_fire = in_valid_reg && out_free;
    // input slot takes a word when empty or its word moves on this cycle
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    chbd_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (step_nxt),
        .res       (step_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_fire) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        state_next = state_reg;
        if (step_fire) begin
            // end of message: drop back to header search with counts cleared
            state_next = in_last_reg ? '0 : step_nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step_fire) begin
            out_res_reg  <= step_res;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.body_len, out_res_reg.header_seen,
                            out_res_reg.out_byte};
    assign m_axis_tuser  = out_res_reg.out_kind;
    assign m_axis_tlast  = out_last_reg;

    // a decoded last word leaves the decoder in its reset state
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_last_reg |=> state_reg == '0)
        else $error("state not cleared after last word");

    // no body counting while still searching for the header end
    a_header_no_body: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_HEADER |-> state_reg.body_count == '0)
        else $error("body count nonzero during header search");

    // body words carry a nonzero count and a seen header
    a_body_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_res_reg.out_kind == KIND_BODY
        |-> out_res_reg.header_seen && out_res_reg.body_len != '0)
        else $error("body word without header or count");

    // result register is never overwritten while holding an untaken word
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !step_fire)
        else $error("result overwritten while stalled");

    // undefined kind code never produced
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> out_res_reg.out_kind != 2'd3)
        else $error("invalid result kind");

endmodule

// ===== verif/http_chunked_body_decoder_unit_tb.sv =====
module http_chunked_body_decoder_unit_tb
    import chbd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 1000;
    localparam int RandomWords   = 320;
    localparam int LongHold      = 60;

    typedef logic [7:0] byte_q_t[$];

    // one expected result word, fields as they leave the block
    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic        seen;
        logic [31:0] total;
        logic        eom;
    } decoded_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;     // [7:0] out_byte, [8] header_seen, [40:9] body_len
    logic [1:0]  m_axis_tuser;     // [1:0] out_kind
    logic        m_axis_tlast;     // end_of_message

    http_chunked_body_decoder_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 aclk = ~aclk;

    // decoder state as the testbench tracks it
    logic [1:0]        crlf_run;
    logic [PhaseW-1:0] dec_phase;
    logic [31:0]       size_acc;
    logic [31:0]       remain;
    logic [31:0]       body_total;

    decoded_word_t decoded_q[$];
    decoded_word_t want_word;

    int  mismatches   = 0;
    int  words_sent   = 0;
    bit  tx_jitter    = 1'b0;
    bit  rx_jitter    = 1'b0;
    int  hold_request = 0;
    int  hold_left    = 0;
    int  rx_gap_left  = 0;

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // bit 4 set when the character is a hex digit, nibble in [3:0]
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
        return 5'd0;
    endfunction

    function automatic void clear_decoder();
        crlf_run   = '0;
        dec_phase  = PH_HEADER;
        size_acc   = '0;
        remain     = '0;
        body_total = '0;
    endfunction

    // advance the tracked decoder by one accepted word, queue the result
    function automatic void decode_predict(input logic [7:0] b, input logic eom);
        logic          crlf;
        logic [4:0]    hx;
        logic [1:0]    kind;
        decoded_word_t w;
        crlf = (b == CharCr) || (b == CharLf);
        hx   = hex_digit(b);
        kind = KIND_DROP;
        case (dec_phase)
            PH_HEADER: begin
                // every byte up to and including the blank line goes out raw
                kind = KIND_HEADER;
                if (b == (crlf_run[0] ? CharLf : CharCr)) begin
                    if (crlf_run == 2'd3) begin
                        crlf_run  = '0;
                        dec_phase = PH_SKIP_PRE;
                    end else begin
                        crlf_run = crlf_run + 2'd1;
                    end
                end else begin
                    crlf_run = (b == CharCr) ? 2'd1 : 2'd0;
                end
            end
            PH_SKIP_PRE: begin
                if (!crlf) begin
                    if (hx[4]) begin
                        size_acc  = 32'(hx[3:0]);
                        dec_phase = PH_SIZE;
                    end else begin
                        size_acc  = '0;
                        dec_phase = PH_DONE;
                    end
                end
            end
            PH_SIZE: begin
                if (hx[4]) begin
                    size_acc = {size_acc[27:0], hx[3:0]};
                end else begin
                    dec_phase = (size_acc == 0) ? PH_DONE : PH_SKIP_POST;
                end
            end
            PH_SKIP_POST: begin
                if (!crlf) begin
                    kind      = KIND_BODY;
                    remain    = size_acc - 32'd1;
                    dec_phase = (remain == 0) ? PH_SKIP_PRE : PH_DATA;
                end
            end
            PH_DATA: begin
                kind   = KIND_BODY;
                remain = remain - 32'd1;
                if (remain == 0) dec_phase = PH_SKIP_PRE;
            end
            default: ;
        endcase
        if (kind == KIND_BODY && body_total != '1) body_total = body_total + 32'd1;
        w.data  = (kind != KIND_DROP) ? b : 8'h00;
        w.kind  = kind;
        w.seen  = (dec_phase != PH_HEADER);
        w.total = body_total;
        w.eom   = eom;
        decoded_q.push_back(w);
        if (eom) clear_decoder();
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender: offer one word, return at the edge it is taken
    task automatic send_word(input logic [7:0] b, input logic eom);
        int gap;
        gap = tx_jitter ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eom;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        decode_predict(b, eom);
        words_sent++;
    endtask

    // a whole response, tlast on its final byte
    task automatic send_msg(input byte_q_t m);
        foreach (m[i]) send_word(m[i], i == m.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (decoded_q.size() != 0);
    endtask

    // well-formed chunked response with random content; optionally cut short
    task automatic build_chunked(ref byte_q_t m, input bit cut_short);
        int    n_hdr;
        int    n_chunks;
        int    size;
        string hex_txt;
        logic [7:0] c;
        m = {};
        n_hdr = $urandom_range(0, 10);
        repeat (n_hdr) begin
            case ($urandom_range(0, 5))
                0:       m.push_back(CharCr);
                1:       m.push_back(CharLf);
                default: m.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        m.push_back(CharCr); m.push_back(CharLf);
        m.push_back(CharCr); m.push_back(CharLf);
        n_chunks = $urandom_range(1, 3);
        repeat (n_chunks) begin
            size = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40)
                                                : $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0) m.push_back("0");
            hex_txt = $sformatf("%0h", size);
            for (int i = 0; i < hex_txt.len(); i++) begin
                c = hex_txt[i];
                // mix upper and lower case letters
                if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
                m.push_back(c);
            end
            // size line ends in CR LF or a bare LF
            if ($urandom_range(0, 3) != 0) m.push_back(CharCr);
            m.push_back(CharLf);
            repeat (size) m.push_back(8'($urandom_range(0, 255)));
            m.push_back(CharCr); m.push_back(CharLf);
        end
        // closing zero chunk, sometimes followed by a trailing byte
        m.push_back("0");
        m.push_back(CharCr); m.push_back(CharLf);
        m.push_back(CharCr); m.push_back(CharLf);
        if ($urandom_range(0, 3) == 0) m.push_back(8'($urandom_range(0, 255)));
        if (cut_short) begin
            size = $urandom_range(1, m.size() - 1);
            while (m.size() > size) void'(m.pop_back());
        end
    endtask

    // no header end ever seen: raw passthrough, matcher restarts on partial runs
    task automatic test_raw_fallback();
        byte_q_t m;
        m = {8'h00, 8'hFF, CharCr, CharCr, CharLf, CharCr, "x"};
        send_msg(m);
    endtask

    // one-byte-wide size ended by a non-hex char, CR inside data,
    // non-hex where a size should start ends decoding
    task automatic test_chunk_decode();
        byte_q_t m;
        m = {CharCr, CharLf, CharCr, CharLf, "2", ";", CharCr, CharLf,
             "Z", CharCr, "G", 8'hFF};
        send_msg(m);
    endtask

    // size wraps to zero after nine digits, so the block stops
    task automatic test_wrapped_size();
        byte_q_t m;
        m = {CharCr, CharLf, CharCr, CharLf, "f", "0", "0", "0", "0",
             "0", "0", "0", "0", CharLf, "7"};
        send_msg(m);
    endtask

    // response ends part way through a chunk
    task automatic test_truncated_chunk();
        byte_q_t m;
        m = {CharCr, CharLf, CharCr, CharLf, "E", CharCr, CharLf, 8'h00, 8'hFF};
        send_msg(m);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_stall();
        byte_q_t m;
        tx_jitter    = 1'b0;
        rx_jitter    = 1'b0;
        hold_request = LongHold;
        build_chunked(m, 1'b0);
        send_msg(m);
        build_chunked(m, 1'b0);
        send_msg(m);
    endtask

    // sender goes quiet until every result is out, then resumes
    task automatic test_pause_until_drained();
        byte_q_t m;
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        build_chunked(m, 1'b0);
        send_msg(m);
        wait_drained();
        build_chunked(m, 1'b0);
        send_msg(m);
    endtask

    // mostly well-formed responses, some cut short, some plain noise
    task automatic test_random_traffic();
        byte_q_t m;
        int      stop_at;
        int      pick;
        stop_at = words_sent + RandomWords;
        while (words_sent < stop_at) begin
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                build_chunked(m, 1'b0);
            end else if (pick < 9) begin
                build_chunked(m, 1'b1);
            end else begin
                m = {};
                repeat ($urandom_range(1, 16)) begin
                    if ($urandom_range(0, 2) == 0)
                        m.push_back($urandom_range(0, 1) ? CharCr : CharLf);
                    else
                        m.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_msg(m);
        end
    endtask

    // receiver: random stalls, plus a long hold when a test asks for one
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (rx_gap_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_jitter) rx_gap_left = pick_gap();
        end
    end

    // result checker: each taken word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: word with nothing expected, expected none, got %0h/%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want_word = decoded_q.pop_front();
                compare_field("out_byte",       32'(want_word.data),  32'(m_axis_tdata[7:0]));
                compare_field("out_kind",       32'(want_word.kind),  32'(m_axis_tuser));
                compare_field("header_seen",    32'(want_word.seen),  32'(m_axis_tdata[8]));
                compare_field("body_len",       want_word.total,      m_axis_tdata[40:9]);
                compare_field("end_of_message", 32'(want_word.eom),   32'(m_axis_tlast));
            end
        end
    end

    // watchdog: too long with no word moving on either side
    initial begin
        int idle;
        idle = 0;
        while (idle < WatchdogLimit) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        clear_decoder();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_raw_fallback();
        test_chunk_decode();
        test_wrapped_size();
        test_truncated_chunk();
        test_output_stall();
        test_pause_until_drained();
        test_random_traffic();

        wait_drained();
        // keep the clock running so a stray extra word would still be caught
        rx_jitter = 1'b0;
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
